@@ rtl/tnsc_pkg.sv @@
// Shared types and code points for the Thai name sequence check.
`timescale 1ns / 1ps
package tnsc_pkg;

  typedef enum logic [3:0] {
    CLS_NONE      = 4'd0,
    CLS_WHITE     = 4'd1,
    CLS_DARKGREEN = 4'd2,
    CLS_GREEN     = 4'd3,
    CLS_ORANGE    = 4'd4,
    CLS_YELLOW    = 4'd5,
    CLS_BLUE      = 4'd6,
    CLS_PURPLE    = 4'd7,
    CLS_PINK      = 4'd8,
    CLS_DARKGREY  = 4'd9
  } tnsc_class_e;

  localparam int unsigned CodeW = 24;

  localparam logic [CodeW-1:0] ConsonantLo  = 24'he0b881;
  localparam logic [CodeW-1:0] ConsonantHi  = 24'he0b8ae;
  localparam logic [CodeW-1:0] DarkGreenA   = 24'he0b8af;
  localparam logic [CodeW-1:0] DarkGreenB   = 24'he0b8bf;
  localparam logic [CodeW-1:0] LeadVowelLo  = 24'he0b980;
  localparam logic [CodeW-1:0] LeadVowelHi  = 24'he0b984;
  localparam logic [CodeW-1:0] DigitLo      = 24'he0b990;
  localparam logic [CodeW-1:0] DigitHi      = 24'he0b999;
  localparam logic [CodeW-1:0] YellowA      = 24'he0b8b0;
  localparam logic [CodeW-1:0] YellowBLo    = 24'he0b8b2;
  localparam logic [CodeW-1:0] YellowBHi    = 24'he0b8b3;
  localparam logic [CodeW-1:0] YellowCLo    = 24'he0b985;
  localparam logic [CodeW-1:0] YellowCHi    = 24'he0b986;
  localparam logic [CodeW-1:0] BlueA        = 24'he0b8b1;
  localparam logic [CodeW-1:0] BlueBLo      = 24'he0b8b4;
  localparam logic [CodeW-1:0] BlueBHi      = 24'he0b8b7;
  localparam logic [CodeW-1:0] PurpleLo     = 24'he0b8b8;
  localparam logic [CodeW-1:0] PurpleHi     = 24'he0b8b9;
  localparam logic [CodeW-1:0] PinkA        = 24'he0b987;
  localparam logic [CodeW-1:0] PinkB        = 24'he0b98c;
  localparam logic [CodeW-1:0] ToneLo       = 24'he0b988;
  localparam logic [CodeW-1:0] ToneHi       = 24'he0b98b;

  localparam logic [4:0] LeadFourByte = 5'h1e;

  typedef struct packed {
    logic fire;
    logic name_valid;
  } tnsc_verdict_t;

endpackage

@@ rtl/tnsc_class.sv @@
// Character class lookup for one joined sequence code.
`timescale 1ns / 1ps
module tnsc_class (
  input  logic [tnsc_pkg::CodeW-1:0] code_i,
  output tnsc_pkg::tnsc_class_e      class_o
);

  function automatic logic in_span(logic [tnsc_pkg::CodeW-1:0] v,
                                   logic [tnsc_pkg::CodeW-1:0] lo,
                                   logic [tnsc_pkg::CodeW-1:0] hi);
    return (v >= lo) && (v <= hi);
  endfunction

  always_comb begin
    if (in_span(code_i, 24'h30, 24'h39) || in_span(code_i, 24'h41, 24'h5a) ||
        in_span(code_i, 24'h61, 24'h7a) ||
        in_span(code_i, tnsc_pkg::ConsonantLo, tnsc_pkg::ConsonantHi)) begin
      class_o = tnsc_pkg::CLS_WHITE;
    end else if (code_i == tnsc_pkg::DarkGreenA || code_i == tnsc_pkg::DarkGreenB) begin
      class_o = tnsc_pkg::CLS_DARKGREEN;
    end else if (in_span(code_i, tnsc_pkg::LeadVowelLo, tnsc_pkg::LeadVowelHi)) begin
      class_o = tnsc_pkg::CLS_GREEN;
    end else if (in_span(code_i, tnsc_pkg::DigitLo, tnsc_pkg::DigitHi)) begin
      class_o = tnsc_pkg::CLS_ORANGE;
    end else if (code_i == tnsc_pkg::YellowA ||
                 in_span(code_i, tnsc_pkg::YellowBLo, tnsc_pkg::YellowBHi) ||
                 in_span(code_i, tnsc_pkg::YellowCLo, tnsc_pkg::YellowCHi)) begin
      class_o = tnsc_pkg::CLS_YELLOW;
    end else if (code_i == tnsc_pkg::BlueA ||
                 in_span(code_i, tnsc_pkg::BlueBLo, tnsc_pkg::BlueBHi)) begin
      class_o = tnsc_pkg::CLS_BLUE;
    end else if (in_span(code_i, tnsc_pkg::PurpleLo, tnsc_pkg::PurpleHi)) begin
      class_o = tnsc_pkg::CLS_PURPLE;
    end else if (code_i == tnsc_pkg::PinkA || code_i == tnsc_pkg::PinkB) begin
      class_o = tnsc_pkg::CLS_PINK;
    end else if (in_span(code_i, tnsc_pkg::ToneLo, tnsc_pkg::ToneHi)) begin
      class_o = tnsc_pkg::CLS_DARKGREY;
    end else begin
      class_o = tnsc_pkg::CLS_NONE;
    end
  end

endmodule

@@ rtl/tnsc_scan.sv @@
// Running sequence state of one name and the per-beat rule check.
`timescale 1ns / 1ps
module tnsc_scan (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    beat_i,
  input  logic [7:0]              name_byte_i,
  input  logic                    last_byte_i,
  output tnsc_pkg::tnsc_verdict_t verdict_o
);

  logic [1:0]            pend_q, pend_d;
  logic [15:0]           part_q, part_d;
  logic                  long_q, long_d;
  tnsc_pkg::tnsc_class_e prev_q, prev_d;
  logic                  first_q, first_d;
  logic                  failed_q, failed_d;

  logic [tnsc_pkg::CodeW-1:0] code;
  tnsc_pkg::tnsc_class_e      cls;
  logic                       finish;
  logic                       bad;

  function automatic logic may_follow(tnsc_pkg::tnsc_class_e p, tnsc_pkg::tnsc_class_e c);
    logic ok;
    unique case (p)
      tnsc_pkg::CLS_WHITE:  ok = 1'b1;
      tnsc_pkg::CLS_GREEN:  ok = (c <= tnsc_pkg::CLS_WHITE);
      tnsc_pkg::CLS_BLUE,
      tnsc_pkg::CLS_PURPLE: ok = (c <= tnsc_pkg::CLS_ORANGE) || (c == tnsc_pkg::CLS_DARKGREY);
      tnsc_pkg::CLS_DARKGREY: ok = (c <= tnsc_pkg::CLS_YELLOW);
      default:              ok = (c <= tnsc_pkg::CLS_ORANGE);
    endcase
    return ok;
  endfunction

  assign code = (pend_q != 2'd0) ? {part_q, name_byte_i} : {16'h0000, name_byte_i};

  tnsc_class u_class (
    .code_i  (code),
    .class_o (cls)
  );

  assign bad = (cls == tnsc_pkg::CLS_NONE) ||
               (first_q && (cls > tnsc_pkg::CLS_ORANGE)) ||
               !may_follow(prev_q, cls);

  always_comb begin
    pend_d   = pend_q;
    part_d   = part_q;
    long_d   = long_q;
    prev_d   = prev_q;
    first_d  = first_q;
    failed_d = failed_q;
    finish   = 1'b0;
    if (pend_q != 2'd0) begin
      part_d = {part_q[7:0], name_byte_i};
      pend_d = pend_q - 2'd1;
      finish = (pend_q == 2'd1) && !failed_q && !long_q;
      if (pend_q == 2'd1) begin
        long_d = 1'b0;
      end
    end else if (!failed_q) begin
      priority if (name_byte_i[7] == 1'b0) begin
        finish = 1'b1;
      end else if (name_byte_i[7:5] == 3'b110) begin
        part_d = {8'h00, name_byte_i};
        pend_d = 2'd1;
      end else if (name_byte_i[7:4] == 4'b1110) begin
        part_d = {8'h00, name_byte_i};
        pend_d = 2'd2;
      end else if (name_byte_i[7:3] == tnsc_pkg::LeadFourByte) begin
        part_d   = {8'h00, name_byte_i};
        pend_d   = 2'd3;
        long_d   = 1'b1;
        failed_d = 1'b1;
      end else begin
        failed_d = 1'b1;
      end
    end
    if (finish) begin
      if (bad) begin
        failed_d = 1'b1;
      end else begin
        prev_d  = cls;
        first_d = 1'b0;
      end
    end
  end

  assign verdict_o.fire       = beat_i && last_byte_i;
  assign verdict_o.name_valid = !failed_d && (pend_d == 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q   <= 2'd0;
      part_q   <= 16'h0000;
      long_q   <= 1'b0;
      prev_q   <= tnsc_pkg::CLS_WHITE;
      first_q  <= 1'b1;
      failed_q <= 1'b0;
    end else if (beat_i) begin
      if (last_byte_i) begin
        pend_q   <= 2'd0;
        part_q   <= 16'h0000;
        long_q   <= 1'b0;
        prev_q   <= tnsc_pkg::CLS_WHITE;
        first_q  <= 1'b1;
        failed_q <= 1'b0;
      end else begin
        pend_q   <= pend_d;
        part_q   <= part_d;
        long_q   <= long_d;
        prev_q   <= prev_d;
        first_q  <= first_d;
        failed_q <= failed_d;
      end
    end
  end

  a_reset_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && last_byte_i |=> (pend_q == 2'd0) && first_q && !failed_q && !long_q)
    else $error("name state not cleared after the last beat");

  a_long_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_q |-> (pend_q != 2'd0) && failed_q)
    else $error("four-byte sequence tracked without pending bytes or failure");

  a_prev_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_q != tnsc_pkg::CLS_NONE)
    else $error("previous class holds the unknown class");

  a_first_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    first_q |-> prev_q == tnsc_pkg::CLS_WHITE)
    else $error("previous class changed before the first character");

endmodule

@@ rtl/thai_name_sequence_check.sv @@
// Top level of the Thai name sequence check: input register, scan and result register.
//
// The block checks a UTF-8 encoded name against the Thai character sequence rules.
// Input channel: in_valid_i with name_byte_i and last_byte_i; the block drives
// in_stall_o. A beat is taken at a rising edge with in_valid_i high and in_stall_o low.
// Each name is a run of beats ending with last_byte_i high.
// Output channel: out_valid_o with name_valid_o; the receiver drives out_stall_i.
// One result beat appears per name, for its last byte, and none for the other bytes.
// The verdict for the last byte passes from the input register through the scan stage
// into the result register. Throughput: one byte per cycle unless the receiver stalls,
// set by the single scan stage updating the running name state from the input register.
// When the receiver stalls with a verdict waiting, the scan stage holds and
// in_stall_o rises once the input register is full; no beat is lost.
// Reset clears the valid flags of the input and result registers and puts the name
// state at the start of a new name.
`timescale 1ns / 1ps
module thai_name_sequence_check (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] name_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       name_valid_o
);

  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_last_q;
  logic       advance;
  logic       out_valid_q;
  logic       out_value_q;

  tnsc_pkg::tnsc_verdict_t verdict;

  assign advance    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      s1_byte_q <= name_byte_i;
      s1_last_q <= last_byte_i;
    end
  end

  tnsc_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .beat_i      (advance),
    .name_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .verdict_o   (verdict)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (verdict.fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (verdict.fire) begin
      out_value_q <= verdict.name_valid;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign name_valid_o = out_value_q;

endmodule

@@ sim/thai_name_sequence_check_test.sv @@
// Self-checking testbench for the Thai name sequence check.
`timescale 1ns / 1ps
module thai_name_sequence_check_test;

  localparam logic [23:0] AsciiNumLo   = 24'h30;
  localparam logic [23:0] AsciiNumHi   = 24'h39;
  localparam logic [23:0] AsciiUpperLo = 24'h41;
  localparam logic [23:0] AsciiUpperHi = 24'h5a;
  localparam logic [23:0] AsciiLowerLo = 24'h61;
  localparam logic [23:0] AsciiLowerHi = 24'h7a;
  localparam logic [2:0]  TwoByteLead   = 3'b110;
  localparam logic [3:0]  ThreeByteLead = 4'he;
  localparam int          RandomBeats   = 500;
  localparam int          ReportLimit   = 10;

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain;
  } name_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] name_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       name_valid_o;

  thai_name_sequence_check dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .name_byte_i  (name_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .name_valid_o (name_valid_o)
  );

  always #5 clk_i = ~clk_i;

  name_beat_t  pending_beats[$];
  logic [7:0]  name_bytes[$];
  logic        verdicts_due[$];
  int          beats_queued = 0;
  int          beats_taken = 0;
  int          verdicts_seen = 0;
  int          names_accepted = 0;
  int          mismatches = 0;
  logic        beat_taken = 1'b0;

  // Running state of the scan, one name at a time.
  logic [1:0]            scan_pending;
  logic [23:0]           scan_code;
  logic                  scan_long;
  tnsc_pkg::tnsc_class_e scan_prev;
  logic                  scan_first;
  logic                  scan_failed;

  function automatic tnsc_pkg::tnsc_class_e code_class(input logic [23:0] code);
    if ((code >= AsciiNumLo && code <= AsciiNumHi) ||
        (code >= AsciiUpperLo && code <= AsciiUpperHi) ||
        (code >= AsciiLowerLo && code <= AsciiLowerHi) ||
        (code >= tnsc_pkg::ConsonantLo && code <= tnsc_pkg::ConsonantHi))
      return tnsc_pkg::CLS_WHITE;
    if (code == tnsc_pkg::DarkGreenA || code == tnsc_pkg::DarkGreenB)
      return tnsc_pkg::CLS_DARKGREEN;
    if (code >= tnsc_pkg::LeadVowelLo && code <= tnsc_pkg::LeadVowelHi)
      return tnsc_pkg::CLS_GREEN;
    if (code >= tnsc_pkg::DigitLo && code <= tnsc_pkg::DigitHi)
      return tnsc_pkg::CLS_ORANGE;
    if (code == tnsc_pkg::YellowA ||
        (code >= tnsc_pkg::YellowBLo && code <= tnsc_pkg::YellowBHi) ||
        (code >= tnsc_pkg::YellowCLo && code <= tnsc_pkg::YellowCHi))
      return tnsc_pkg::CLS_YELLOW;
    if (code == tnsc_pkg::BlueA ||
        (code >= tnsc_pkg::BlueBLo && code <= tnsc_pkg::BlueBHi))
      return tnsc_pkg::CLS_BLUE;
    if (code >= tnsc_pkg::PurpleLo && code <= tnsc_pkg::PurpleHi)
      return tnsc_pkg::CLS_PURPLE;
    if (code == tnsc_pkg::PinkA || code == tnsc_pkg::PinkB)
      return tnsc_pkg::CLS_PINK;
    if (code >= tnsc_pkg::ToneLo && code <= tnsc_pkg::ToneHi)
      return tnsc_pkg::CLS_DARKGREY;
    return tnsc_pkg::CLS_NONE;
  endfunction

  function automatic logic class_may_follow(input tnsc_pkg::tnsc_class_e prev,
                                            input tnsc_pkg::tnsc_class_e cls);
    case (prev)
      tnsc_pkg::CLS_WHITE: return 1'b1;
      tnsc_pkg::CLS_GREEN: return cls <= tnsc_pkg::CLS_WHITE;
      tnsc_pkg::CLS_BLUE, tnsc_pkg::CLS_PURPLE:
        return cls <= tnsc_pkg::CLS_ORANGE || cls == tnsc_pkg::CLS_DARKGREY;
      tnsc_pkg::CLS_DARKGREY: return cls <= tnsc_pkg::CLS_YELLOW;
      default: return cls <= tnsc_pkg::CLS_ORANGE;
    endcase
  endfunction

  task automatic clear_scan();
    scan_pending = 2'd0;
    scan_code = 24'h0;
    scan_long = 1'b0;
    scan_prev = tnsc_pkg::CLS_WHITE;
    scan_first = 1'b1;
    scan_failed = 1'b0;
  endtask

  task automatic close_char(input logic [23:0] code);
    tnsc_pkg::tnsc_class_e cls;
    cls = code_class(code);
    if (cls == tnsc_pkg::CLS_NONE || (scan_first && cls > tnsc_pkg::CLS_ORANGE) ||
        !class_may_follow(scan_prev, cls)) begin
      scan_failed = 1'b1;
    end else begin
      scan_prev = cls;
      scan_first = 1'b0;
    end
  endtask

  task automatic scan_name_byte(input logic [7:0] b, input logic last);
    if (scan_pending != 2'd0) begin
      scan_code = {scan_code[15:0], b};
      scan_pending = scan_pending - 2'd1;
      if (scan_pending == 2'd0 && !scan_failed && !scan_long) close_char(scan_code);
      if (scan_pending == 2'd0) scan_long = 1'b0;
    end else if (!scan_failed) begin
      if (!b[7]) begin
        close_char({16'h0, b});
      end else if (b[7:5] == TwoByteLead) begin
        scan_code = {16'h0, b};
        scan_pending = 2'd1;
      end else if (b[7:4] == ThreeByteLead) begin
        scan_code = {16'h0, b};
        scan_pending = 2'd2;
      end else if (b[7:3] == tnsc_pkg::LeadFourByte) begin
        scan_code = {16'h0, b};
        scan_pending = 2'd3;
        scan_long = 1'b1;
        scan_failed = 1'b1;
      end else begin
        scan_failed = 1'b1;
      end
    end
    if (last) begin
      verdicts_due.push_back(!scan_failed && scan_pending == 2'd0);
      clear_scan();
    end
  endtask

  task automatic flag_bad_verdict(input string what, input logic want, input logic got);
    mismatches++;
    if (mismatches <= ReportLimit)
      $display("%0t: %s: expected %0b, got %0b", $realtime, what, want, got);
  endtask

  // Stimulus building.
  task automatic push_code(input logic [23:0] code);
    if (code[23:8] == 16'h0) begin
      name_bytes.push_back(code[7:0]);
    end else begin
      name_bytes.push_back(code[23:16]);
      name_bytes.push_back(code[15:8]);
      name_bytes.push_back(code[7:0]);
    end
  endtask

  task automatic flush_name(input logic drain);
    name_beat_t beat;
    for (int i = 0; i < name_bytes.size(); i++) begin
      beat.data = name_bytes[i];
      beat.last = (i == name_bytes.size() - 1);
      beat.drain = drain && (i == 0);
      pending_beats.push_back(beat);
      beats_queued++;
    end
    name_bytes.delete();
  endtask

  function automatic logic [23:0] random_code_of(input tnsc_pkg::tnsc_class_e cls);
    logic [23:0] c;
    do begin
      case ($urandom_range(0, 2))
        0: c = {17'h0, 7'($urandom_range(0, 127))};
        1: c = {16'he0b8, 8'($urandom_range(8'h80, 8'hbf))};
        default: c = {16'he0b9, 8'($urandom_range(8'h80, 8'h9f))};
      endcase
    end while (code_class(c) != cls);
    return c;
  endfunction

  task automatic push_junk();
    case ($urandom_range(0, 4))
      0: name_bytes.push_back(8'($urandom));
      1: begin
        name_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
        name_bytes.push_back(8'($urandom));
      end
      2: begin
        name_bytes.push_back(8'($urandom_range(8'hf0, 8'hf7)));
        repeat (3) name_bytes.push_back(8'($urandom));
      end
      3: begin
        name_bytes.push_back(8'($urandom_range(8'he0, 8'hef)));
        repeat (2) name_bytes.push_back(8'($urandom));
      end
      default: begin
        if ($urandom_range(0, 1) == 0) name_bytes.push_back(8'($urandom_range(8'h80, 8'hbf)));
        else name_bytes.push_back(8'($urandom_range(8'hf8, 8'hff)));
      end
    endcase
  endtask

  task automatic queue_random_name(input logic drain);
    int                    nchars;
    int                    style;
    tnsc_pkg::tnsc_class_e prev;
    tnsc_pkg::tnsc_class_e cls;
    logic                  first;
    nchars = $urandom_range(1, 6);
    style = $urandom_range(0, 9);
    prev = tnsc_pkg::CLS_WHITE;
    first = 1'b1;
    for (int i = 0; i < nchars; i++) begin
      if (style < 7 || $urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 11) == 0) begin
          cls = tnsc_pkg::tnsc_class_e'($urandom_range(1, 9));
        end else begin
          do cls = tnsc_pkg::tnsc_class_e'($urandom_range(1, 9));
          while (!((!first || cls <= tnsc_pkg::CLS_ORANGE) && class_may_follow(prev, cls)));
        end
        push_code(random_code_of(cls));
        prev = cls;
        first = 1'b0;
      end else begin
        push_junk();
      end
    end
    // A sequence left unfinished by the end of the name.
    if (style == 9) begin
      case ($urandom_range(0, 2))
        0: name_bytes.push_back(8'($urandom_range(8'hc0, 8'hdf)));
        1: begin
          name_bytes.push_back(8'he0);
          if ($urandom_range(0, 1) == 0) name_bytes.push_back(8'hb8);
        end
        default: begin
          name_bytes.push_back(8'($urandom_range(8'hf0, 8'hf7)));
          repeat ($urandom_range(0, 2)) name_bytes.push_back(8'($urandom));
        end
      endcase
    end
    flush_name(drain);
  endtask

  // Input side: bursts of beats with random gaps.
  int         burst_left = 0;
  int         gap_left = 0;
  logic       offer;
  name_beat_t beat_out;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      offer = in_valid_i && !beat_taken;
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_beats.size() != 0 &&
                     !(pending_beats[0].drain && verdicts_due.size() != 0)) begin
          beat_out = pending_beats.pop_front();
          name_byte_i <= beat_out.data;
          last_byte_i <= beat_out.last;
          offer = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      in_valid_i <= offer;
    end
  end

  // Output side: stall pattern in phases, plus two long hold-offs.
  int rx_cycle = 0;
  int hold_left = 0;
  int mode_left = 0;
  int stall_mode = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      rx_cycle++;
      if (rx_cycle == 150 || rx_cycle == 500) hold_left = 120;
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 80);
        end else begin
          mode_left--;
        end
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor: every accepted beat updates the prediction, every verdict is checked.
  logic want;

  always @(posedge clk_i) begin
    beat_taken = 1'b0;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        beat_taken = 1'b1;
        beats_taken++;
        scan_name_byte(name_byte_i, last_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        verdicts_seen++;
        if (verdicts_due.size() == 0) begin
          flag_bad_verdict("verdict with no name outstanding", 1'bx, name_valid_o);
        end else begin
          want = verdicts_due.pop_front();
          if (want) names_accepted++;
          if (name_valid_o !== want) flag_bad_verdict("name verdict mismatch", want, name_valid_o);
        end
      end
    end
  end

  initial begin
    clear_scan();
    // Directed names: ASCII extremes, a valid Thai syllable, a bad first class,
    // four-byte and two-byte sequences, a cut-off sequence, bytes after a failure.
    name_bytes.push_back(8'h30); flush_name(1'b0);
    name_bytes.push_back(8'h00); flush_name(1'b0);
    name_bytes.push_back(8'hff); flush_name(1'b0);
    push_code(tnsc_pkg::ConsonantLo);
    push_code(tnsc_pkg::ToneLo);
    push_code(tnsc_pkg::YellowBLo);
    flush_name(1'b0);
    push_code(tnsc_pkg::BlueBLo); flush_name(1'b0);
    name_bytes = '{8'hf0, 8'h90, 8'h80, 8'h80}; flush_name(1'b0);
    name_bytes = '{8'hc3, 8'ha9}; flush_name(1'b0);
    name_bytes = '{8'he0, 8'hb8}; flush_name(1'b0);
    name_bytes = '{8'h80, 8'h41}; flush_name(1'b0);
    queue_random_name(1'b1);
    while (beats_queued < RandomBeats + 25) queue_random_name($urandom_range(0, 11) == 0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_beats.size() != 0 || in_valid_i) @(posedge clk_i);
    while (verdicts_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Scanned %0d name bytes and checked %0d verdicts (%0d names valid).",
             beats_taken, verdicts_seen, names_accepted);
    $display("Mismatches: %0d.", mismatches);
    if (mismatches == 0 && verdicts_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #(64'd2_000_000);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
